// ===== sv/clps_pkg.sv =====
// Package for the charlieplexed LED PWM scanner.
// Holds scan sizes, the gamma table and the pin-pair table; no dependencies.
package clps_pkg;

	localparam int SLOTS   = 128;
	localparam int PAIRS   = 32;
	localparam int ENTRIES = 64;

	localparam int SLOT_W = $clog2(SLOTS);
	localparam int PAIR_W = (PAIRS > 1) ? $clog2(PAIRS) : 1;
	localparam int IDX_W  = $clog2(ENTRIES);

	localparam int PINS   = 7;
	localparam int LVL_W  = 4;
	localparam int DUTY_W = 7;

	// channel A switches to the upper bank at this pair
	localparam logic [4:0] A_SPLIT  = 5'd13;
	localparam logic [5:0] A_OFFSET = 6'd32;
	localparam logic [5:0] B_OFFSET = 6'd13;

	localparam logic [DUTY_W-1:0] GAMMA_DUTY [16] = '{
		7'd0, 7'd1, 7'd2, 7'd4, 7'd5, 7'd10, 7'd15, 7'd21,
		7'd29, 7'd39, 7'd51, 7'd65, 7'd82, 7'd101, 7'd122, 7'd127
	};

	localparam logic [2:0] PIN_HI [32] = '{
		3'd6, 3'd0, 3'd6, 3'd1, 3'd6, 3'd2, 3'd6, 3'd3, 3'd6, 3'd4, 3'd6, 3'd5,
		3'd5, 3'd0, 3'd5, 3'd1, 3'd5, 3'd2, 3'd5, 3'd3, 3'd5, 3'd4,
		3'd4, 3'd0, 3'd4, 3'd1, 3'd4, 3'd2, 3'd4, 3'd3,
		3'd3, 3'd0
	};

	localparam logic [2:0] PIN_LO [32] = '{
		3'd0, 3'd6, 3'd1, 3'd6, 3'd2, 3'd6, 3'd3, 3'd6, 3'd4, 3'd6, 3'd5, 3'd6,
		3'd0, 3'd5, 3'd1, 3'd5, 3'd2, 3'd5, 3'd3, 3'd5, 3'd4, 3'd5,
		3'd0, 3'd4, 3'd1, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4,
		3'd0, 3'd3
	};

	typedef enum logic {
		ACT_TICK  = 1'b0,
		ACT_WRITE = 1'b1
	} action_t;

	typedef struct packed {
		logic [PINS-1:0] dir;
		logic [PINS-1:0] lvl;
	} drive_t;

	function automatic logic [PINS-1:0] pin_mask(input logic [2:0] pin);
		return PINS'(1) << pin;
	endfunction

	function automatic drive_t port_drive(input logic [4:0] pair, input logic on);
		drive_t d;
		d.dir = '0;
		d.lvl = '0;
		if (on) begin
			d.dir = pin_mask(PIN_HI[pair]) | pin_mask(PIN_LO[pair]);
			d.lvl = pin_mask(PIN_HI[pair]);
		end
		return d;
	endfunction

endpackage

// ===== sv/charlieplex_led_pwm_scanner_core.sv =====
// Charlieplexed LED PWM scanner: brightness store, scan counters, drive logic.
// Depends on clps_pkg for sizes, gamma and pin-pair tables.
//
// Input channel (in_valid/in_ready) carries one word per item: action selects
// a PWM tick or a brightness write (entry_index, level). A write updates the
// 64-entry store and yields nothing; a tick yields one output word with the
// port A and port B pin enables and levels plus the pair and slot scanned.
// An accepted tick is registered in the read stage, which reads the store,
// then in the output stage, which looks up gamma, compares against the slot
// and registers the drive presented on the output channel (out_valid/out_ready).
// Throughput: one word per clock on either kind of item while the receiver does
// not stall, set by the single store read per tick and the registered output stage.
// Reset clears the scan counters, the pipeline and the store's valid bits,
// so every entry reads as zero (dark) until written.
// When the receiver stalls, the output word holds, the read stage fills and
// then in_ready drops; nothing is lost or repeated.
module charlieplex_led_pwm_scanner_core
	import clps_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             action,
	input  logic [5:0]       entry_index,
	input  logic [3:0]       level,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [6:0]       dir_a,
	output logic [6:0]       out_a,
	output logic [6:0]       dir_b,
	output logic [6:0]       out_b,
	output logic [4:0]       pair_number,
	output logic [6:0]       slot_number
);

	logic [LVL_W-1:0]  mem [ENTRIES];
	logic [ENTRIES-1:0] written_q;

	logic [SLOT_W-1:0] slot_q;
	logic [PAIR_W-1:0] pair_q;

	logic              valid_s1;
	logic [LVL_W-1:0]  rd_a_s1, rd_b_s1;
	logic              wv_a_s1, wv_b_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [4:0]        pair_s1;

	logic              accept, tick_acc, write_acc, adv_s1;
	logic [4:0]        pair_cur;
	logic [IDX_W-1:0]  idx_a, idx_b;
	logic [LVL_W-1:0]  lvl_a, lvl_b;
	logic [DUTY_W-1:0] duty_a, duty_b;
	logic              on_a, on_b;
	drive_t            drv_a, drv_b;

	assign adv_s1    = valid_s1 && (!out_valid || out_ready);
	assign in_ready  = !valid_s1 || adv_s1;
	assign accept    = in_valid && in_ready;
	assign tick_acc  = accept && (action == ACT_TICK);
	assign write_acc = accept && (action == ACT_WRITE);

	assign pair_cur = 5'(pair_q);
	assign idx_a    = (pair_cur < A_SPLIT) ? 6'(pair_cur) : 6'(pair_cur) + A_OFFSET;
	assign idx_b    = 6'(pair_cur) + B_OFFSET;

	// scan counters: slot every tick, pair on slot wrap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			pair_q <= '0;
		end else if (tick_acc) begin
			if (slot_q == SLOT_W'(SLOTS - 1)) begin
				slot_q <= '0;
				if (pair_q == PAIR_W'(PAIRS - 1))
					pair_q <= '0;
				else
					pair_q <= pair_q + 1'b1;
			end else begin
				slot_q <= slot_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			written_q <= '0;
		else if (write_acc)
			written_q[entry_index] <= 1'b1;
	end

	// brightness store: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (write_acc)
			mem[entry_index] <= level;
		if (tick_acc) begin
			rd_a_s1 <= mem[idx_a];
			rd_b_s1 <= mem[idx_b];
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			wv_a_s1 <= written_q[idx_a];
			wv_b_s1 <= written_q[idx_b];
			slot_s1 <= slot_q;
			pair_s1 <= pair_cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (tick_acc)
			valid_s1 <= 1'b1;
		else if (adv_s1)
			valid_s1 <= 1'b0;
	end

	assign lvl_a  = wv_a_s1 ? rd_a_s1 : '0;
	assign lvl_b  = wv_b_s1 ? rd_b_s1 : '0;
	assign duty_a = GAMMA_DUTY[lvl_a];
	assign duty_b = GAMMA_DUTY[lvl_b];
	assign on_a   = 9'(slot_s1) < 9'(duty_a);
	assign on_b   = 9'(slot_s1) < 9'(duty_b);
	assign drv_a  = port_drive(pair_s1, on_a);
	assign drv_b  = port_drive(pair_s1, on_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (adv_s1)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			dir_a       <= drv_a.dir;
			out_a       <= drv_a.lvl;
			dir_b       <= drv_b.dir;
			out_b       <= drv_b.lvl;
			pair_number <= pair_s1;
			slot_number <= 7'(slot_s1);
		end
	end

	// a driven port A always has exactly its two pins enabled, high pin set
	a_drive_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (dir_a != '0) |-> ($countones(dir_a) == 2) && ($countones(out_a) == 1)
			&& ((dir_a & out_a) == out_a))
		else $error("port A drive malformed");

	a_released: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (dir_b == '0) |-> (out_b == '0))
		else $error("port B level without enable");

	a_write_holds: assert property (@(posedge clk) disable iff (!arst_n)
		write_acc |=> $stable(slot_q) && $stable(pair_q))
		else $error("counters moved on a write");

	a_slot_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		tick_acc && (slot_q == SLOT_W'(SLOTS - 1)) |=> (slot_q == '0))
		else $error("slot counter failed to wrap");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for charlieplex_led_pwm_scanner_core: ticks and brightness writes go in,
// and a scoreboard class predicts and checks every port drive word that comes out.
// Depends on clps_pkg and the scanner core RTL.
module tb_top
	import clps_pkg::*;
();

	localparam int HOLD_CYCLES = 60;
	localparam int MAX_PRINTS  = 40;
	localparam int RUN_ITEMS   = 430;

	typedef struct packed {
		logic [PINS-1:0]   dir_a;
		logic [PINS-1:0]   out_a;
		logic [PINS-1:0]   dir_b;
		logic [PINS-1:0]   out_b;
		logic [PAIR_W-1:0] pair;
		logic [SLOT_W-1:0] slot;
	} drive_word_t;

	// Tracks the brightness store and scan position, queues predicted drive words.
	class scan_scoreboard;
		logic [LVL_W-1:0]  level_store [ENTRIES];
		logic [PAIR_W-1:0] scan_pair;
		logic [SLOT_W-1:0] scan_slot;
		drive_word_t       expected_drives [$];
		int                errors;
		int                words_checked;
		int                writes_seen;
		int                scans_done;

		function new();
			foreach (level_store[i])
				level_store[i] = '0;
			scan_pair     = '0;
			scan_slot     = '0;
			errors        = 0;
			words_checked = 0;
			writes_seen   = 0;
			scans_done    = 0;
		endfunction

		task report(string msg);
			if (errors < MAX_PRINTS)
				$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		function void predict_port(input logic [IDX_W-1:0] entry,
		                           output logic [PINS-1:0] dir, output logic [PINS-1:0] lvl);
			logic [PINS-1:0] hi_bit;
			logic [PINS-1:0] lo_bit;
			hi_bit = PINS'(1) << PIN_HI[scan_pair];
			lo_bit = PINS'(1) << PIN_LO[scan_pair];
			if (scan_slot < GAMMA_DUTY[level_store[entry]]) begin
				dir = hi_bit | lo_bit;
				lvl = hi_bit;
			end else begin
				dir = '0;
				lvl = '0;
			end
		endfunction

		function void note_word(input action_t act, input logic [IDX_W-1:0] idx,
		                        input logic [LVL_W-1:0] lv);
			drive_word_t      w;
			logic [IDX_W-1:0] entry_a;
			if (act == ACT_WRITE) begin
				level_store[idx] = lv;
				writes_seen++;
				return;
			end
			// channel A moves to the upper bank from the split pair on
			entry_a = (scan_pair < A_SPLIT) ? IDX_W'(scan_pair) : IDX_W'(scan_pair) + A_OFFSET;
			predict_port(entry_a, w.dir_a, w.out_a);
			predict_port(IDX_W'(scan_pair) + B_OFFSET, w.dir_b, w.out_b);
			w.pair = scan_pair;
			w.slot = scan_slot;
			expected_drives.push_back(w);
			if (scan_slot == SLOT_W'(SLOTS - 1)) begin
				scan_slot = '0;
				if (scan_pair == PAIR_W'(PAIRS - 1)) begin
					scan_pair = '0;
					scans_done++;
				end else begin
					scan_pair++;
				end
			end else begin
				scan_slot++;
			end
		endfunction

		function string field_msg(string name, logic [7:0] got, logic [7:0] want,
		                          drive_word_t at);
			return $sformatf("%s got %0h want %0h at pair %0d slot %0d",
			                 name, got, want, at.pair, at.slot);
		endfunction

		task check_result(input drive_word_t got);
			drive_word_t want;
			if (expected_drives.size() == 0) begin
				report($sformatf("output word with nothing pending (pair %0d slot %0d)",
				                 got.pair, got.slot));
				return;
			end
			want = expected_drives.pop_front();
			words_checked++;
			if (got.dir_a !== want.dir_a)
				report(field_msg("dir_a", 8'(got.dir_a), 8'(want.dir_a), want));
			if (got.out_a !== want.out_a)
				report(field_msg("out_a", 8'(got.out_a), 8'(want.out_a), want));
			if (got.dir_b !== want.dir_b)
				report(field_msg("dir_b", 8'(got.dir_b), 8'(want.dir_b), want));
			if (got.out_b !== want.out_b)
				report(field_msg("out_b", 8'(got.out_b), 8'(want.out_b), want));
			if (got.pair !== want.pair)
				report(field_msg("pair_number", 8'(got.pair), 8'(want.pair), want));
			if (got.slot !== want.slot)
				report(field_msg("slot_number", 8'(got.slot), 8'(want.slot), want));
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	action_t           action;
	logic [IDX_W-1:0]  entry_index;
	logic [LVL_W-1:0]  level;
	logic              out_valid;
	logic              out_ready;
	logic [PINS-1:0]   dir_a;
	logic [PINS-1:0]   out_a;
	logic [PINS-1:0]   dir_b;
	logic [PINS-1:0]   out_b;
	logic [PAIR_W-1:0] pair_number;
	logic [SLOT_W-1:0] slot_number;

	int             send_idle_pct;
	int             recv_stall_pct;
	bit             hold_req;
	scan_scoreboard sb;

	charlieplex_led_pwm_scanner_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.entry_index (entry_index),
		.level       (level),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.dir_a       (dir_a),
		.out_a       (out_a),
		.dir_b       (dir_b),
		.out_b       (out_b),
		.pair_number (pair_number),
		.slot_number (slot_number)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Starts and ends at a falling edge; returns once the word is taken.
	task automatic send_word(input action_t act, input logic [IDX_W-1:0] idx,
	                         input logic [LVL_W-1:0] lv);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid    <= 1'b0;
			action      <= action_t'($urandom_range(1));
			entry_index <= IDX_W'($urandom);
			level       <= LVL_W'($urandom);
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		action      <= act;
		entry_index <= idx;
		level       <= lv;
		do @(posedge clk); while (!in_ready);
		sb.note_word(act, idx, lv);
		@(negedge clk);
	endtask

	// Mostly ticks; writes lean toward the entries of the pair being scanned.
	task automatic run_random(input int count);
		logic [PAIR_W-1:0] p;
		int                pick;
		repeat (count) begin
			p    = sb.scan_pair;
			pick = $urandom_range(99);
			if (pick < 4)
				send_word(ACT_WRITE,
				          (p < A_SPLIT) ? IDX_W'(p) : IDX_W'(p) + A_OFFSET,
				          LVL_W'($urandom));
			else if (pick < 8)
				send_word(ACT_WRITE, IDX_W'(p) + B_OFFSET, LVL_W'($urandom));
			else if (pick < 11)
				send_word(ACT_WRITE, IDX_W'($urandom), LVL_W'($urandom));
			else
				send_word(ACT_TICK, IDX_W'($urandom), LVL_W'($urandom));
		end
	endtask

	// Receiver: random stalls, or a long hold-off when asked
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result({dir_a, out_a, dir_b, out_b, pair_number, slot_number});
	end

	initial begin
		#2_000_000;
		$display("timeout: %0d drive words still pending", sb.expected_drives.size());
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		sb             = new();
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		action         = ACT_TICK;
		entry_index    = '0;
		level          = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req       = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// dark store, ignored payload at its top values
		send_word(ACT_TICK, '1, '1);
		send_word(ACT_WRITE, 6'd0, 4'd15);
		send_word(ACT_WRITE, 6'd13, 4'd1);
		// shortest pulses on channel B, full duty on A
		send_word(ACT_TICK, '0, '0);
		send_word(ACT_TICK, '0, '0);
		send_word(ACT_WRITE, 6'd13, 4'd2);
		send_word(ACT_TICK, '1, '0);
		send_word(ACT_WRITE, 6'd13, 4'd3);
		send_word(ACT_TICK, '0, '1);
		send_word(ACT_TICK, '0, '0);
		send_word(ACT_WRITE, 6'd63, 4'd0);
		send_word(ACT_WRITE, 6'd0, 4'd0);
		send_word(ACT_TICK, '0, '0);
		send_word(ACT_WRITE, 6'd63, 4'd15);
		send_word(ACT_WRITE, 6'd44, 4'd15);
		send_word(ACT_WRITE, 6'd45, 4'd8);
		send_word(ACT_WRITE, 6'd32, 4'd7);
		send_word(ACT_TICK, '1, '1);
		send_word(ACT_TICK, '0, '0);

		// hold the output off while words keep coming, so the input stalls
		hold_req = 1'b1;
		run_random(RUN_ITEMS);
		send_idle_pct = 55;
		run_random(RUN_ITEMS);
		send_idle_pct  = 0;
		recv_stall_pct = 55;
		run_random(RUN_ITEMS);
		send_idle_pct  = 14;
		recv_stall_pct = 14;
		run_random(RUN_ITEMS);
		in_valid <= 1'b0;

		while (sb.expected_drives.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Checked %0d drive words over %0d full scans of all pairs, %0d store writes.",
		         sb.words_checked, sb.scans_done, sb.writes_seen);
		$display("Handshake mixes: free-running, sender gaps, output stalls, both, and a %0d-cycle hold-off.",
		         HOLD_CYCLES);
		if (sb.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
